/* design/pbp_pkg.sv */
// ----------------------------------------------------------------------------
// Page buffer pool package
// Shared request and response types and fixed constants.
// ----------------------------------------------------------------------------
package pbp_pkg;

   localparam logic [1:0] OP_GET     = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_FLUSH   = 2'd2;
   localparam logic [1:0] OP_UNDEF   = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ALL_PINNED = 2'd1;
   localparam logic [1:0] ST_NOT_RES    = 2'd2;
   localparam logic [1:0] ST_NOT_PINNED = 2'd3;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_FRAMES = 1'b1;

   localparam int DEFAULT_FRAMES = 8;
   localparam int MAX_ACTIVE     = 16;
   localparam int PIN_BITS       = 8;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  file_id;
      logic [15:0] page_number;
      logic        mark_dirty;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  frame_index;
      logic        was_hit;
      logic        load_needed;
      logic        writeback_needed;
      logic [7:0]  writeback_file;
      logic [15:0] writeback_page;
      logic        last_result;
   } rsp_type;

endpackage

/* design/pbp_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* design/page_buffer_pool_lru_mru_core.sv */
// ----------------------------------------------------------------------------
// Page buffer pool with LRU / MRU replacement
// Frame table manager: lookup, victim choice, pin and dirty tracking, flush.
// ----------------------------------------------------------------------------
//  channel  | ports                         | handshake
//  request  | start, busy, req_data         | transfer when start & !busy
//  response | rsp_strobe, rsp_data          | one cycle strobe, no stall
//  config   | csr_valid/ready, idx, data    | transfer when valid & ready
//
// Each request scans the active frames through the frame memory, one read a
// cycle, so the single read port sets the length of an item. A get that hits
// or loads and a release of a resident page then read and rewrite the target
// frame. A flush holds each write-back in a pending register so that the
// final one can carry the last flag; the final response of any item appears
// in the first cycle with busy low. Reset (synchronous) clears the valid bits,
// the access clock and the control registers; a frame entry is written whole
// when it is filled, so no clearing pass is needed. The receiver cannot stall.
// ----------------------------------------------------------------------------
module page_buffer_pool_lru_mru_core
   import pbp_pkg::*;
#(
   parameter int FRAMES     = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_index,
   input  logic [4:0] csr_data
);
   localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CAP = (FRAMES < MAX_ACTIVE) ? FRAMES : MAX_ACTIVE;
   // Entry: file, page, pins, dirty, stamp.
   localparam int EW = 8 + 16 + PIN_BITS + 1 + STAMP_BITS;
   localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_LAST = 3'd2;
   localparam logic [2:0] S_DONE = 3'd3;
   localparam logic [2:0] S_VRD  = 3'd4;
   localparam logic [2:0] S_VWR  = 3'd5;

   typedef struct packed {
      logic [7:0]            file;
      logic [15:0]           page;
      logic [PIN_BITS-1:0]   pins;
      logic                  dirty;
      logic [STAMP_BITS-1:0] stamp;
   } entry_type;

   logic [2:0]  state_ff, state_in;
   logic        policy_ff;
   logic [4:0]  frames_ff;
   logic [STAMP_BITS-1:0] clock_ff, clock_in;
   logic [FRAMES-1:0] valid_ff, valid_in;
   req_type     req_ff;
   logic [AW:0] scan_ff, scan_in;       // address issued
   logic [AW:0] cnt_ff;                 // active frame count for this item
   logic        rv_ff;                  // read data valid for frame rv_idx_ff
   logic [AW-1:0] rv_idx_ff;
   logic        hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic        emp_ff, emp_in;
   logic [AW-1:0] emp_idx_ff, emp_idx_in;
   logic        vic_ff, vic_in;
   logic [AW-1:0] vic_idx_ff, vic_idx_in;
   logic [STAMP_BITS-1:0] vic_st_ff, vic_st_in;
   logic        fl_any_ff, fl_any_in;
   logic        rsp_strobe_ff;
   rsp_type     rsp_ff;
   logic        rsp_strobe_in;
   rsp_type     rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_ent, rd_ent;
   logic [EW-1:0] rd_raw;

   pbp_ram #(.WIDTH(EW), .DEPTH(FRAMES)) u_frames (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_ent),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );
   assign rd_ent = entry_type'(rd_raw);

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Active frame count at request time.
   logic [AW:0] act_cnt;
   always_comb begin
      logic [5:0] n;
      n = {1'b0, frames_ff};
      if (n == 6'd0) n = 6'(DEFAULT_FRAMES);
      if (n > 6'(CAP)) n = 6'(CAP);
      act_cnt = (AW + 1)'(n);
   end

   logic [STAMP_BITS-1:0] tick_val;
   assign tick_val = (clock_ff == STAMP_MAX) ? clock_ff : clock_ff + 1'b1;

   // Frame that the update reads and writes: the hit, else the first empty
   // frame, else the victim.
   logic [AW-1:0] tgt_idx;
   assign tgt_idx = hit_ff ? hit_idx_ff : (emp_ff ? emp_idx_ff : vic_idx_ff);

   // Frame under inspection in this cycle.
   logic    cur_valid, cur_match;
   assign cur_valid = rv_ff && valid_ff[rv_idx_ff];
   assign cur_match = cur_valid && rd_ent.file == req_ff.file_id
                      && rd_ent.page == req_ff.page_number;

   always_comb begin
      rsp_type r;
      entry_type e;
      state_in   = state_ff;
      scan_in    = scan_ff;
      clock_in   = clock_ff;
      valid_in   = valid_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      emp_in     = emp_ff;
      emp_idx_in = emp_idx_ff;
      vic_in     = vic_ff;
      vic_idx_in = vic_idx_ff;
      vic_st_in  = vic_st_ff;
      fl_any_in  = fl_any_ff;
      wr_en      = 1'b0;
      wr_addr    = rv_idx_ff;
      wr_ent     = rd_ent;
      rd_addr    = scan_ff[AW-1:0];
      r          = '0;
      e          = rd_ent;
      rsp_strobe_in = 1'b0;
      rsp_in     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in  = S_SCAN;
               scan_in   = '0;
               hit_in    = 1'b0;
               emp_in    = 1'b0;
               vic_in    = 1'b0;
               fl_any_in = 1'b0;
               if (req_data.opcode == OP_GET) clock_in = tick_val;
            end
         end
         S_SCAN, S_LAST: begin
            // Issue next read while inspecting the previous one.
            if (state_ff == S_SCAN) begin
               if (scan_ff + 1'b1 >= cnt_ff) state_in = S_LAST;
               scan_in = scan_ff + 1'b1;
            end else begin
               state_in = S_DONE;
            end
            if (rv_ff) begin
               if (cur_match && !hit_ff) begin
                  hit_in = 1'b1;
                  hit_idx_in = rv_idx_ff;
               end
               if (!cur_valid && !emp_ff) begin
                  emp_in = 1'b1;
                  emp_idx_in = rv_idx_ff;
               end
               if (cur_valid && rd_ent.pins == '0) begin
                  if (!vic_ff || (!policy_ff && rd_ent.stamp < vic_st_ff)
                      || (policy_ff && rd_ent.stamp > vic_st_ff)) begin
                     vic_in = 1'b1;
                     vic_idx_in = rv_idx_ff;
                     vic_st_in = rd_ent.stamp;
                  end
               end
               if (req_ff.opcode == OP_FLUSH && cur_valid && rd_ent.dirty) begin
                  // Write-back goes to the pending register; last flag settled in S_DONE.
                  e.dirty = 1'b0;
                  wr_en = 1'b1;
                  wr_ent = e;
                  fl_any_in = 1'b1;
                  r.frame_index = 4'(rv_idx_ff);
                  r.writeback_needed = 1'b1;
                  r.writeback_file = rd_ent.file;
                  r.writeback_page = rd_ent.page;
                  rsp_strobe_in = 1'b1;
                  rsp_in = r;
               end
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
            r.last_result = 1'b1;
            case (req_ff.opcode)
               OP_GET: begin
                  if (hit_ff || emp_ff || vic_ff) begin
                     rd_addr = tgt_idx;
                     state_in = S_VRD;
                  end else begin
                     r.status = ST_ALL_PINNED;
                     rsp_strobe_in = 1'b1;
                     rsp_in = r;
                  end
               end
               OP_RELEASE: begin
                  if (hit_ff) begin
                     rd_addr = tgt_idx;
                     state_in = S_VRD;
                  end else begin
                     r.status = ST_NOT_RES;
                     rsp_strobe_in = 1'b1;
                     rsp_in = r;
                  end
               end
               OP_FLUSH: begin
                  // Last flag: a trailing write-back is still held in pend_ff.
                  if (!fl_any_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = r;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = r;
               end
            endcase
         end
         S_VRD: begin
            // Keep the address so the entry is on the read port next cycle.
            rd_addr = tgt_idx;
            state_in = S_VWR;
         end
         S_VWR: begin
            state_in = S_IDLE;
            wr_addr = tgt_idx;
            r.frame_index = 4'(wr_addr);
            r.last_result = 1'b1;
            rsp_strobe_in = 1'b1;
            if (req_ff.opcode == OP_GET) begin
               wr_en = 1'b1;
               if (hit_ff) begin
                  if (rd_ent.pins != '1) e.pins = rd_ent.pins + 1'b1;
                  e.stamp = clock_ff;
                  r.was_hit = 1'b1;
               end else begin
                  r.load_needed = 1'b1;
                  if (!emp_ff && rd_ent.dirty) begin
                     r.writeback_needed = 1'b1;
                     r.writeback_file = rd_ent.file;
                     r.writeback_page = rd_ent.page;
                  end
                  e.file = req_ff.file_id;
                  e.page = req_ff.page_number;
                  e.pins = PIN_BITS'(1);
                  e.dirty = 1'b0;
                  e.stamp = clock_ff;
                  valid_in[wr_addr] = 1'b1;
               end
            end else begin
               if (rd_ent.pins == '0) begin
                  r.status = ST_NOT_PINNED;
               end else begin
                  wr_en = 1'b1;
                  if (req_ff.mark_dirty) e.dirty = 1'b1;
                  e.pins = rd_ent.pins - 1'b1;
                  clock_in = tick_val;
                  e.stamp = tick_val;
               end
            end
            wr_ent = e;
            rsp_in = r;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Flush write-backs are held in a pending register. A held one
   // goes out when the next arrives, and the final one leaves in S_DONE with
   // the last flag set, once the scan is known to be over.
   logic    flush_end, flush_push;
   rsp_type pend_ff, pend_last;
   logic    pend_v_ff;
   assign flush_end  = (state_ff == S_DONE) && req_ff.opcode == OP_FLUSH && fl_any_ff;
   assign flush_push = rsp_strobe_in && req_ff.opcode == OP_FLUSH && state_ff != S_DONE;

   always_comb begin
      pend_last = pend_ff;
      pend_last.last_result = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         policy_ff     <= 1'b0;
         frames_ff     <= 5'(DEFAULT_FRAMES);
         clock_ff      <= '0;
         valid_ff      <= '0;
         rv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clock_ff  <= clock_in;
         valid_ff  <= valid_in;
         rv_ff     <= (state_ff == S_SCAN);
         rsp_strobe_ff <= flush_push ? pend_v_ff : (rsp_strobe_in || flush_end);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POLICY) policy_ff <= csr_data[0];
            else frames_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
      end else if (flush_push) begin
         pend_v_ff <= 1'b1;
      end else if (flush_end) begin
         pend_v_ff <= 1'b0;
      end
      if (flush_push) pend_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      rv_idx_ff  <= scan_ff[AW-1:0];
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      emp_ff     <= emp_in;
      emp_idx_ff <= emp_idx_in;
      vic_ff     <= vic_in;
      vic_idx_ff <= vic_idx_in;
      vic_st_ff  <= vic_st_in;
      fl_any_ff  <= fl_any_in;
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_data;
         cnt_ff <= act_cnt;
      end
      if (flush_end) begin
         rsp_ff <= pend_last;
      end else if (flush_push) begin
         rsp_ff <= pend_ff;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   // Assertions.
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready) else $error("csr ready while busy");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_result) |-> !busy)
      else $error("final response while busy");
   a_clock_mono: assert property (@(posedge clock) disable iff (reset)
      clock_ff >= $past(clock_ff)) else $error("access clock went back");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Page buffer pool core testbench
// Drives get, release, flush and unknown requests at the core under several
// replacement policies and frame counts. A behavioral frame table predicts
// every response, and each response is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
   import pbp_pkg::*;

   localparam int FRAMES = 16;

   // One row of the directed table. When has_typed is set, the first response
   // of the row is the literal value typed in; otherwise the predictor decides.
   typedef struct {
      req_type rq;
      bit      has_typed;
      rsp_type rs;
   } dir_row_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_index;
   logic [4:0] csr_data;

   // Shadow copy of the frame table and the configuration registers.
   logic        fr_valid [FRAMES];
   logic [7:0]  fr_file  [FRAMES];
   logic [15:0] fr_page  [FRAMES];
   logic [7:0]  fr_pins  [FRAMES];
   logic        fr_dirty [FRAMES];
   logic [31:0] fr_stamp [FRAMES];
   logic [31:0] use_clock;
   logic        cfg_policy;
   logic [4:0]  cfg_frames;

   // Responses still owed by the core, oldest first.
   rsp_type pending_rsp [$];
   int      fail_count;
   bit      quiet;

   page_buffer_pool_lru_mru_core #(
      .FRAMES     (FRAMES),
      .STAMP_BITS (32)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The frame count register folds zero onto the default and clips at
   // MAX_ACTIVE.
   function automatic int active_frames();
      if (cfg_frames == 0) return DEFAULT_FRAMES;
      if (cfg_frames > MAX_ACTIVE) return MAX_ACTIVE;
      return cfg_frames;
   endfunction

   function automatic void bump_clock();
      if (use_clock != 32'hFFFF_FFFF) use_clock = use_clock + 32'd1;
   endfunction

   function automatic int find_page(int n, logic [7:0] f, logic [15:0] p);
      for (int i = 0; i < n; i++)
         if (fr_valid[i] && fr_file[i] == f && fr_page[i] == p) return i;
      return -1;
   endfunction

   // An empty frame wins outright; otherwise the unpinned frame with the
   // oldest (LRU) or newest (MRU) stamp, ties going to the lowest index.
   function automatic int pick_evict_frame(int n);
      int best;
      best = -1;
      for (int i = 0; i < n; i++)
         if (!fr_valid[i]) return i;
      for (int i = 0; i < n; i++) begin
         if (fr_pins[i] != 0) continue;
         if (best < 0) best = i;
         else if (!cfg_policy && fr_stamp[i] < fr_stamp[best]) best = i;
         else if (cfg_policy && fr_stamp[i] > fr_stamp[best]) best = i;
      end
      return best;
   endfunction

   // Applies one accepted request to the shadow table and appends the
   // responses it causes to the pending queue.
   task automatic predict_request(input req_type r, input bit has_typed,
                                  input rsp_type typed);
      int      n;
      int      idx;
      int      first;
      rsp_type o;
      n = active_frames();
      first = pending_rsp.size();
      o = '0;
      o.last_result = 1'b1;
      case (r.opcode)
         OP_GET: begin
            bump_clock();
            idx = find_page(n, r.file_id, r.page_number);
            if (idx >= 0) begin
               if (fr_pins[idx] != 8'hFF) fr_pins[idx]++;
               fr_stamp[idx] = use_clock;
               o.frame_index = 4'(idx);
               o.was_hit = 1'b1;
            end else begin
               idx = pick_evict_frame(n);
               if (idx < 0) begin
                  o.status = ST_ALL_PINNED;
               end else begin
                  o.frame_index = 4'(idx);
                  o.load_needed = 1'b1;
                  if (fr_valid[idx] && fr_dirty[idx]) begin
                     o.writeback_needed = 1'b1;
                     o.writeback_file = fr_file[idx];
                     o.writeback_page = fr_page[idx];
                  end
                  fr_valid[idx] = 1'b1;
                  fr_file[idx]  = r.file_id;
                  fr_page[idx]  = r.page_number;
                  fr_pins[idx]  = 8'd1;
                  fr_dirty[idx] = 1'b0;
                  fr_stamp[idx] = use_clock;
               end
            end
            pending_rsp.push_back(o);
         end
         OP_RELEASE: begin
            idx = find_page(n, r.file_id, r.page_number);
            if (idx < 0) begin
               o.status = ST_NOT_RES;
            end else if (fr_pins[idx] == 0) begin
               o.status = ST_NOT_PINNED;
               o.frame_index = 4'(idx);
            end else begin
               if (r.mark_dirty) fr_dirty[idx] = 1'b1;
               fr_pins[idx]--;
               bump_clock();
               fr_stamp[idx] = use_clock;
               o.frame_index = 4'(idx);
            end
            pending_rsp.push_back(o);
         end
         OP_FLUSH: begin
            // One write-back per dirty frame; only the final one is marked last.
            for (int i = 0; i < n; i++) begin
               if (fr_valid[i] && fr_dirty[i]) begin
                  o = '0;
                  o.frame_index = 4'(i);
                  o.writeback_needed = 1'b1;
                  o.writeback_file = fr_file[i];
                  o.writeback_page = fr_page[i];
                  fr_dirty[i] = 1'b0;
                  pending_rsp.push_back(o);
               end
            end
            if (pending_rsp.size() == first) begin
               o = '0;
               o.last_result = 1'b1;
               pending_rsp.push_back(o);
            end else begin
               pending_rsp[pending_rsp.size() - 1].last_result = 1'b1;
            end
         end
         default: pending_rsp.push_back(o);
      endcase
      if (has_typed) pending_rsp[first] = typed;
   endtask

   // Presents one request and holds it until the core takes it. Start is left
   // high so that a back-to-back request does not toggle it within one step.
   task automatic send_request(input req_type r, input bit has_typed,
                               input rsp_type typed);
      @(negedge clock);
      start = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      predict_request(r, has_typed, typed);
   endtask

   task automatic idle_sender();
      if (!quiet && $urandom_range(99) < 14) begin
         @(negedge clock);
         start = 1'b0;
         req_data = $bits(req_type)'($urandom);
         repeat ($urandom_range(4)) @(negedge clock);
      end
   endtask

   // Register writes happen only with the core idle and nothing owed.
   task automatic write_csr(input logic idx, input logic [4:0] value);
      @(negedge clock);
      start = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_POLICY) cfg_policy = value[0];
      else cfg_frames = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      start = 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (MAX_ACTIVE + 8) @(posedge clock);
   endtask

   // Random request. Addresses mostly come from a small set so that hits,
   // evictions and valid releases are common; a few use the full range.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r = '0;
      pick = $urandom_range(99);
      if (pick < 50) r.opcode = OP_GET;
      else if (pick < 85) r.opcode = OP_RELEASE;
      else if (pick < 93) r.opcode = OP_FLUSH;
      else r.opcode = OP_UNDEF;
      if ($urandom_range(9) == 0) begin
         r.file_id = 8'($urandom);
         r.page_number = 16'($urandom);
      end else begin
         r.file_id = 8'($urandom_range(2));
         r.page_number = 16'($urandom_range(9));
      end
      r.mark_dirty = 1'($urandom);
      return r;
   endfunction

   function automatic dir_row_type row(input logic [1:0] op, input logic [7:0] f,
                                       input logic [15:0] p, input logic md,
                                       input bit typed, input rsp_type rs);
      dir_row_type d;
      d.rq = '{op, f, p, md};
      d.has_typed = typed;
      d.rs = rs;
      return d;
   endfunction

   function automatic void check_field(string name, int unsigned exp_v,
                                       int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // Response checker. Every strobe is matched against the oldest prediction.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("response with none expected: %h", rsp_data);
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            check_field("status", e.status, rsp_data.status);
            check_field("frame_index", e.frame_index, rsp_data.frame_index);
            check_field("was_hit", e.was_hit, rsp_data.was_hit);
            check_field("load_needed", e.load_needed, rsp_data.load_needed);
            check_field("writeback_needed", e.writeback_needed,
                        rsp_data.writeback_needed);
            check_field("writeback_file", e.writeback_file, rsp_data.writeback_file);
            check_field("writeback_page", e.writeback_page, rsp_data.writeback_page);
            check_field("last_result", e.last_result, rsp_data.last_result);
         end
      end
   end

   // Hard stop in case the core hangs.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      dir_row_type dir_rows [$];
      logic [4:0]  phase_frames [7];
      logic        phase_policy [7];
      rsp_type     none;

      none = '0;
      fail_count = 0;
      quiet = 1'b0;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_POLICY;
      csr_data = '0;
      for (int i = 0; i < FRAMES; i++) begin
         fr_valid[i] = 1'b0;
         fr_file[i]  = '0;
         fr_page[i]  = '0;
         fr_pins[i]  = '0;
         fr_dirty[i] = 1'b0;
         fr_stamp[i] = '0;
      end
      use_clock = '0;
      cfg_policy = 1'b0;
      cfg_frames = 5'd8;

      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, run at the reset settings (LRU, eight frames). Misses
      // fill empty frames in order, releases cover absent and unpinned pages,
      // flush covers both the dirty and the clean case.
      dir_rows.push_back(row(OP_GET, 8'h00, 16'h0000, 1'b0, 1,
                             '{ST_OK, 4'd0, 1'b0, 1'b1, 1'b0, 8'h0, 16'h0, 1'b1}));
      dir_rows.push_back(row(OP_GET, 8'hFF, 16'hFFFF, 1'b0, 1,
                             '{ST_OK, 4'd1, 1'b0, 1'b1, 1'b0, 8'h0, 16'h0, 1'b1}));
      dir_rows.push_back(row(OP_GET, 8'h00, 16'h0000, 1'b0, 1,
                             '{ST_OK, 4'd0, 1'b1, 1'b0, 1'b0, 8'h0, 16'h0, 1'b1}));
      dir_rows.push_back(row(OP_RELEASE, 8'h01, 16'h0001, 1'b0, 1,
                             '{ST_NOT_RES, 4'd0, 1'b0, 1'b0, 1'b0, 8'h0, 16'h0, 1'b1}));
      dir_rows.push_back(row(OP_RELEASE, 8'h00, 16'h0000, 1'b1, 1,
                             '{ST_OK, 4'd0, 1'b0, 1'b0, 1'b0, 8'h0, 16'h0, 1'b1}));
      dir_rows.push_back(row(OP_RELEASE, 8'h00, 16'h0000, 1'b0, 0, none));
      dir_rows.push_back(row(OP_RELEASE, 8'h00, 16'h0000, 1'b0, 1,
                             '{ST_NOT_PINNED, 4'd0, 1'b0, 1'b0, 1'b0, 8'h0, 16'h0, 1'b1}));
      dir_rows.push_back(row(OP_RELEASE, 8'hFF, 16'hFFFF, 1'b1, 0, none));
      dir_rows.push_back(row(OP_FLUSH, 8'h00, 16'h0000, 1'b0, 0, none));
      dir_rows.push_back(row(OP_FLUSH, 8'hFF, 16'hFFFF, 1'b1, 1,
                             '{ST_OK, 4'd0, 1'b0, 1'b0, 1'b0, 8'h0, 16'h0, 1'b1}));
      dir_rows.push_back(row(OP_UNDEF, 8'hFF, 16'hFFFF, 1'b1, 1,
                             '{ST_OK, 4'd0, 1'b0, 1'b0, 1'b0, 8'h0, 16'h0, 1'b1}));
      // Make frame 0 dirty again so that its eviction needs a write-back.
      dir_rows.push_back(row(OP_GET, 8'h00, 16'h0000, 1'b0, 0, none));
      dir_rows.push_back(row(OP_RELEASE, 8'h00, 16'h0000, 1'b1, 0, none));
      for (int i = 0; i < 8; i++)
         dir_rows.push_back(row(OP_GET, 8'h05, 16'(10 + i), 1'b0, 0, none));
      // Every frame is now pinned.
      dir_rows.push_back(row(OP_GET, 8'h05, 16'h0020, 1'b0, 1,
                             '{ST_ALL_PINNED, 4'd0, 1'b0, 1'b0, 1'b0, 8'h0, 16'h0, 1'b1}));
      dir_rows.push_back(row(OP_RELEASE, 8'h00, 16'h0000, 1'b0, 1,
                             '{ST_NOT_RES, 4'd0, 1'b0, 1'b0, 1'b0, 8'h0, 16'h0, 1'b1}));

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].rq, dir_rows[i].has_typed, dir_rows[i].rs);
         idle_sender();
      end
      drain_responses();

      // Random phases. Each phase picks a policy and a frame count, covering
      // a single frame, the full pool, the zero default and an oversized count.
      phase_policy = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      phase_frames = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd12};
      for (int ph = 0; ph < 7; ph++) begin
         write_csr(CSR_POLICY, phase_policy[ph]);
         write_csr(CSR_FRAMES, phase_frames[ph]);
         // The fourth phase runs with no idle cycles at all.
         quiet = (ph == 3);
         for (int k = 0; k < 20; k++) begin
            send_request(random_request(), 0, none);
            idle_sender();
         end
         drain_responses();
      end

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
design/pbp_pkg.sv
design/pbp_ram.sv
design/page_buffer_pool_lru_mru_core.sv
tb/tb_top.sv
